// ----- design/poisson_loss_and_gradient_assert.svh -----
// ----------------------------------------------------------------------------
// poisson loss assertion macros
// shared property forms used by the poisson loss block, clocked on clock and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef POISSON_LOSS_AND_GRADIENT_ASSERT_SVH
`define POISSON_LOSS_AND_GRADIENT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PLG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/plg_pkg.sv -----
// ----------------------------------------------------------------------------
// plg_pkg
// types, microcode program and constants of the poisson loss block
// ----------------------------------------------------------------------------
`default_nettype none

package plg_pkg;

   localparam int PRED_W  = 20;
   localparam int LABEL_W = 16;
   localparam int GRAD_W  = 33;
   localparam int LOSS_W  = 64;
   localparam int MUL_W   = 33;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 104;

   localparam logic [31:0] L2E_Q31 = 32'hB8AA3B29;
   localparam logic [29:0] LN2_Q30 = 30'h2C5C85FE;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [63:0] EXP_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

   // floor(2^31 / k), entry zero unused
   localparam logic [31:0] RECIP_TABLE [16] = '{
      32'd0,         32'd2147483648, 32'd1073741824, 32'd715827882,
      32'd536870912, 32'd429496729,  32'd357913941,  32'd306783378,
      32'd268435456, 32'd238609294,  32'd214748364,  32'd195225786,
      32'd178956970, 32'd165191049,  32'd153391689,  32'd143165576
   };

   typedef enum logic [3:0] {
      OP_T,
      OP_Z,
      OP_YX,
      OP_PZ,
      OP_RC,
      OP_FIX,
      OP_SCALE,
      OP_TERM,
      OP_ACC
   } op_type;

   typedef enum logic {
      JMP_NONE,
      JMP_LOOP
   } jump_type;

   localparam int PROG_LEN = 9;
   localparam int PC_W     = $clog2(PROG_LEN);
   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type   op;
      jump_type jump;
      pc_type   target;
      logic     final_step;
   } cword_type;

   localparam pc_type LOOP_TOP = pc_type'(3);

   localparam cword_type PROGRAM [PROG_LEN] = '{
      '{OP_T,     JMP_NONE, pc_type'(0), 1'b0},
      '{OP_Z,     JMP_NONE, pc_type'(0), 1'b0},
      '{OP_YX,    JMP_NONE, pc_type'(0), 1'b0},
      '{OP_PZ,    JMP_NONE, pc_type'(0), 1'b0},
      '{OP_RC,    JMP_NONE, pc_type'(0), 1'b0},
      '{OP_FIX,   JMP_LOOP, LOOP_TOP,    1'b0},
      '{OP_SCALE, JMP_NONE, pc_type'(0), 1'b0},
      '{OP_TERM,  JMP_NONE, pc_type'(0), 1'b0},
      '{OP_ACC,   JMP_NONE, pc_type'(0), 1'b1}
   };

   typedef struct packed {
      logic   active;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic hold;
      logic loop_more;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/plg_sequencer.sv -----
// ----------------------------------------------------------------------------
// plg_sequencer
// step counter over the microcode program, with the series loop jump
// ----------------------------------------------------------------------------
`default_nettype none

module plg_sequencer import plg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);

   logic      run_ff, run_in;
   pc_type    pc_ff, pc_in;
   cword_type cw;

   assign cw = PROGRAM[pc_ff];

   // next step
   always_comb begin
      run_in = run_ff;
      pc_in  = pc_ff;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
            pc_in  = '0;
         end
      end else if (!stat.hold) begin
         if (cw.final_step) begin
            run_in = 1'b0;
            pc_in  = '0;
         end else if (cw.jump == JMP_LOOP && stat.loop_more) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_type'(pc_ff + 1'b1);
         end
      end
   end

   // control word to the datapath
   always_comb begin
      ctrl.active = run_ff;
      ctrl.op     = cw.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff  <= '0;
      end else begin
         run_ff <= run_in;
         pc_ff  <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/poisson_loss_and_gradient.sv -----
// ----------------------------------------------------------------------------
// poisson_loss_and_gradient
// a request is accepted only while the sequencer is idle, so a new transaction is taken only
//   after the previous one has run its whole program on the single shared multiplier,
//   stepping through the exp series three steps per term
// a response not taken holds the last microcode step until rsp_tready
// reset: synchronous, clears the sequencer, response valid and loss accumulator
// ----------------------------------------------------------------------------
`default_nettype none
`include "poisson_loss_and_gradient_assert.svh"

module poisson_loss_and_gradient import plg_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int EXP_TERMS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // prediction[19:0], label[35:20], zero pad
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // gradient[32:0], total_loss[96:33], zero pad
   output logic                       rsp_tuser    // loss_valid
);

   // fraction point of the product prediction * log2(e) in q31
   localparam int FB = FRAC_BITS + 31;
   localparam int KW = $clog2(EXP_TERMS);
   localparam int M_W = 16;

   ctrl_type ctrl;
   stat_type stat;
   logic     in_fire;
   logic     advance;
   logic     acc_fire;

   // captured transaction
   logic signed [PRED_W-1:0]  x_ff, x_in;
   logic        [LABEL_W-1:0] y_ff, y_in;
   logic                      last_ff, last_in;

   // datapath registers
   logic signed [63:0]     t_ff, t_in;
   logic        [29:0]     z_ff, z_in;
   logic signed [M_W-1:0]  m_ff, m_in;
   logic signed [36:0]     yx_ff, yx_in;
   logic        [30:0]     p_ff, p_in;
   logic        [30:0]     w_ff, w_in;
   logic        [30:0]     q_ff, q_in;
   logic        [KW-1:0]   k_ff, k_in;
   logic        [61:0]     e_ff, e_in;
   logic signed [GRAD_W-1:0] grad_ff, grad_in;
   logic signed [63:0]     term_ff, term_in;
   logic signed [63:0]     acc_ff, acc_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   // shared multiplier
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;

   // step temporaries
   logic signed [MUL_W-1:0] x_ext;
   logic        [35:0]      rem;
   logic                    corr;
   logic signed [M_W-1:0]   s_val, s_neg;
   logic        [63:0]      v_shl;
   logic signed [63:0]      e_s, y_shl, diff, term_ext;
   logic signed [64:0]      sum;
   logic signed [63:0]      sat;

   assign req_tready = !ctrl.active;
   assign in_fire    = req_tvalid && req_tready;

   // the last step stalls while the response register is occupied and not being taken
   assign stat.hold      = ctrl.active && ctrl.op == OP_ACC && rsp_valid_ff && !rsp_tready;
   assign stat.loop_more = k_ff != KW'(1);
   assign advance        = ctrl.active && !stat.hold;
   assign acc_fire       = advance && ctrl.op == OP_ACC;

   plg_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (in_fire),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign x_ext = {{(MUL_W-PRED_W){x_ff[PRED_W-1]}}, x_ff};

   // operand selection for the one multiplier
   always_comb begin
      case (ctrl.op)
         OP_T: begin
            mul_a = x_ext;
            mul_b = {1'b0, L2E_Q31};
         end
         OP_Z: begin
            mul_a = {3'b0, t_ff[FB-1 -: 30]};
            mul_b = {3'b0, LN2_Q30};
         end
         OP_YX: begin
            mul_a = {{(MUL_W-LABEL_W){1'b0}}, y_ff};
            mul_b = x_ext;
         end
         OP_PZ: begin
            mul_a = {2'b0, p_ff};
            mul_b = {3'b0, z_ff};
         end
         OP_RC: begin
            mul_a = {2'b0, w_ff};
            mul_b = {1'b0, RECIP_TABLE[4'(k_ff)]};
         end
         OP_FIX: begin
            mul_a = {2'b0, q_ff};
            mul_b = {{(MUL_W-KW){1'b0}}, k_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // datapath step
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      last_in = last_ff;
      t_in    = t_ff;
      z_in    = z_ff;
      m_in    = m_ff;
      yx_in   = yx_ff;
      p_in    = p_ff;
      w_in    = w_ff;
      q_in    = q_ff;
      k_in    = k_ff;
      e_in    = e_ff;
      grad_in = grad_ff;
      term_in = term_ff;
      acc_in  = acc_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      rem      = {5'b0, w_ff} - prod[35:0];
      corr     = rem >= 36'(k_ff);
      s_val    = m_ff + $signed(M_W'(FRAC_BITS - 30));
      s_neg    = -s_val;
      v_shl    = {33'b0, p_ff} << s_val[4:0];
      e_s      = $signed({2'b0, e_ff});
      y_shl    = $signed({48'b0, y_ff} << FRAC_BITS);
      diff     = e_s - y_shl;
      term_ext = {{27{yx_ff[36]}}, yx_ff};
      sum      = {acc_ff[63], acc_ff} + {term_ff[63], term_ff};
      if (sum[64] != sum[63]) begin
         sat = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
         sat = sum[63:0];
      end

      if (in_fire) begin
         x_in    = req_tdata[PRED_W-1:0];
         y_in    = req_tdata[PRED_W +: LABEL_W];
         last_in = req_tlast;
      end

      if (advance) begin
         case (ctrl.op)
            OP_T: begin
               t_in = prod[63:0];
            end
            OP_Z: begin
               // integer part of the base-2 exponent, series start values
               z_in = prod[59:30];
               m_in = M_W'(t_ff >>> FB);
               p_in = ONE_Q30;
               k_in = KW'(EXP_TERMS - 1);
            end
            OP_YX: begin
               yx_in = prod[36:0];
            end
            OP_PZ: begin
               w_in = prod[60:30];
            end
            OP_RC: begin
               // reciprocal estimate, at most one short of the quotient
               q_in = prod[61:31];
            end
            OP_FIX: begin
               p_in = ONE_Q30 + q_ff + {30'b0, corr};
               k_in = KW'(k_ff - 1'b1);
            end
            OP_SCALE: begin
               if (!s_val[M_W-1]) begin
                  if (s_val >= 31) begin
                     e_in = EXP_CAP[61:0];
                  end else if (v_shl > EXP_CAP) begin
                     e_in = EXP_CAP[61:0];
                  end else begin
                     e_in = v_shl[61:0];
                  end
               end else if (s_neg >= 63) begin
                  e_in = '0;
               end else begin
                  e_in = 62'({33'b0, p_ff} >> s_neg[5:0]);
               end
            end
            OP_TERM: begin
               if (diff > 64'sd4294967295) begin
                  grad_in = {1'b0, {32{1'b1}}};
               end else if (diff < -64'sd4294967296) begin
                  grad_in = {1'b1, 32'b0};
               end else begin
                  grad_in = diff[GRAD_W-1:0];
               end
               term_in = e_s - term_ext;
            end
            OP_ACC: begin
               rsp_data_in = {7'b0, (last_ff ? sat : 64'sd0), grad_ff};
               rsp_user_in = last_ff;
               acc_in      = last_ff ? 64'sd0 : sat;
            end
            default: begin
            end
         endcase
      end
   end

   // response register, refilled only when empty or being taken
   always_comb begin
      if (acc_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      last_ff     <= last_in;
      t_ff        <= t_in;
      z_ff        <= z_in;
      m_ff        <= m_in;
      yx_ff       <= yx_in;
      p_ff        <= p_in;
      w_ff        <= w_in;
      q_ff        <= q_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      grad_ff     <= grad_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `PLG_ASSERT_NEXT(a_start_runs, in_fire, ctrl.active, "accepted request did not start program")
   `PLG_ASSERT_SAME(a_rsp_free, acc_fire, !rsp_valid_ff || rsp_tready, "response overwritten")
   `PLG_ASSERT_NEXT(a_acc_clear, acc_fire && last_ff, acc_ff == 64'sd0, "loss not cleared on last")
   `PLG_ASSERT_SAME(a_loss_zero, rsp_tvalid && !rsp_tuser, rsp_data_ff[96:33] == 64'd0, "loss not zero")
   `PLG_ASSERT_SAME(a_k_live, ctrl.active && ctrl.op == OP_FIX, k_ff != '0, "series index hit zero")

endmodule

`default_nettype wire
